[sv/multi_timer_queue_unit_assert.svh]
// Assertion macros for the timer queue port checker.
`ifndef MULTI_TIMER_QUEUE_UNIT_ASSERT_SVH
`define MULTI_TIMER_QUEUE_UNIT_ASSERT_SVH

// Checked at every edge once reset is released; expects clk and rst in scope.
`define MTQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("timer queue check failed");

// Checked at every edge, reset cycles included.
`define MTQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("timer queue reset check failed");

`endif

[sv/mtq_pkg.sv]
// Types, codes and constants for the timer queue unit.
package mtq_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int MAILBOXES = 64;

  localparam logic [15:0] FREE_MARK = 16'hFFFF;
  localparam logic [15:0] DUR_MAX = 16'hFFFE;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_STOPPED = 3'd1;
  localparam logic [2:0] KIND_EXPIRED = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NO_FREE = 2'd1;
  localparam logic [1:0] ERR_BAD_STOP = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] duration;
    logic [5:0]  mailbox;
    logic [15:0] ret_value;
    logic [7:0]  stop_slot;
    logic [63:0] ready_mask;
  } mtq_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [5:0]  out_mailbox;
    logic [15:0] out_value;
    logic [1:0]  error_code;
    logic        last;
  } mtq_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_READ,
    ST_TICK_PROC,
    ST_TICK_DONE,
    ST_STOP_READ,
    ST_STOP_PROC
  } mtq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic do_start;
    logic do_error;
    logic walk_init;
    logic tick_step;
    logic stop_step;
    logic emit_done;
  } mtq_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_nonempty;
    logic slot_free;
    logic stop_ok;
    logic at_tail;
    logic stop_hit;
  } mtq_sts_t;

endpackage

[sv/multi_timer_queue_unit.sv]
// Top level of the timer queue unit: controller plus datapath.
//
//   channel   ports                          accepted when
//   command   start, busy, item              start high and busy low
//   result    result_valid, result           every cycle result_valid is high
//
// A start, a tick of an empty list, or a command that ends in an error, leaves the unit idle
// and answers in the next cycle.
// A stop walks the list from the head, in a read and a process state per slot, up to the one
// stopped. A tick walks every linked slot in a read and a process state, as the slot stores
// have a single read port, then ends in a done state; expired results stream out on the way.
// Reset empties the list and frees every slot; the receiver cannot stall.
module multi_timer_queue_unit #(
  parameter int SLOTS = mtq_pkg::SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mtq_pkg::mtq_in_t  item,
  output logic              result_valid,
  output mtq_pkg::mtq_out_t result
);
  import mtq_pkg::*;

  mtq_ctl_t ctl;
  mtq_sts_t sts;

  mtq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  mtq_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

[sv/mtq_ctrl.sv]
// Controller state machine of the timer queue unit.
module mtq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        command,
  input  mtq_pkg::mtq_sts_t sts,
  output mtq_pkg::mtq_ctl_t ctl,
  output logic              busy
);
  import mtq_pkg::*;

  mtq_state_t state;
  mtq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          unique case (command)
            CMD_TICK: begin
              if (sts.list_nonempty) begin
                ctl.walk_init = 1'b1;
                state_next = ST_TICK_READ;
              end else begin
                ctl.emit_done = 1'b1;
              end
            end
            CMD_START: begin
              if (sts.slot_free) begin
                ctl.do_start = 1'b1;
              end else begin
                ctl.do_error = 1'b1;
              end
            end
            CMD_STOP: begin
              if (sts.stop_ok) begin
                ctl.walk_init = 1'b1;
                state_next = ST_STOP_READ;
              end else begin
                ctl.do_error = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK_READ: state_next = ST_TICK_PROC;
      ST_TICK_PROC: begin
        ctl.tick_step = 1'b1;
        state_next = sts.at_tail ? ST_TICK_DONE : ST_TICK_READ;
      end
      ST_TICK_DONE: begin
        ctl.emit_done = 1'b1;
        state_next = ST_IDLE;
      end
      ST_STOP_READ: state_next = ST_STOP_PROC;
      ST_STOP_PROC: begin
        ctl.stop_step = 1'b1;
        state_next = sts.stop_hit ? ST_IDLE : ST_STOP_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[sv/mtq_datapath.sv]
// Slot store, linked list pointers and result register of the timer queue unit.
module mtq_datapath #(
  parameter int SLOTS = mtq_pkg::SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  mtq_pkg::mtq_in_t  item,
  input  mtq_pkg::mtq_ctl_t ctl,
  output mtq_pkg::mtq_sts_t sts,
  output mtq_pkg::mtq_out_t result,
  output logic              result_valid
);
  import mtq_pkg::*;

  localparam int IW = $clog2(SLOTS);

  // Per-slot stores; only slots marked active are processed by a walk.
  logic [15:0]   rem_mem [SLOTS];
  logic [5:0]    mbx_mem [SLOTS];
  logic [15:0]   val_mem [SLOTS];
  logic [IW-1:0] link_mem [SLOTS];

  logic [15:0]   rem_rd;
  logic [5:0]    mbx_rd;
  logic [15:0]   val_rd;
  logic [IW-1:0] link_rd;

  logic [SLOTS-1:0] active;
  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic             list_nonempty;
  logic [IW-1:0]    walk_ptr;
  logic [IW-1:0]    prev_ptr;
  logic             prev_valid;
  logic [63:0]      mask_q;
  logic [IW-1:0]    stop_idx;

  logic [IW-1:0] free_idx;
  logic          slot_free;
  logic [IW-1:0] req_idx;
  logic          req_in_range;
  logic [15:0]   rem_dec;
  logic          mbx_ready;
  logic          expire;
  logic          unlink;
  logic          at_tail;
  logic          stop_hit;

  logic          rem_we;
  logic [IW-1:0] rem_wa;
  logic [15:0]   rem_wd;
  logic          link_we;
  logic [IW-1:0] link_wa;
  logic [IW-1:0] link_wd;

  mtq_out_t      result_next;

  always_comb begin
    free_idx = '0;
    slot_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx = IW'(i);
        slot_free = 1'b1;
      end
    end
  end

  assign req_idx = item.stop_slot[IW-1:0];
  assign req_in_range = (9'(item.stop_slot) < 9'(SLOTS));

  assign rem_dec = (rem_rd == 16'd0) ? 16'd0 : rem_rd - 16'd1;
  assign mbx_ready = (7'(mbx_rd) < 7'(MAILBOXES)) && mask_q[mbx_rd];
  assign expire = (rem_dec == 16'd0) && mbx_ready;
  assign at_tail = (walk_ptr == tail);
  assign stop_hit = (walk_ptr == stop_idx);
  assign unlink = (ctl.tick_step && expire) || (ctl.stop_step && stop_hit);

  assign sts.list_nonempty = list_nonempty;
  assign sts.slot_free = slot_free;
  assign sts.stop_ok = req_in_range && active[req_idx];
  assign sts.at_tail = at_tail;
  assign sts.stop_hit = stop_hit;

  always_comb begin
    rem_we = 1'b0;
    rem_wa = walk_ptr;
    rem_wd = rem_dec;
    if (ctl.do_start) begin
      rem_we = 1'b1;
      rem_wa = free_idx;
      rem_wd = (item.duration == FREE_MARK) ? DUR_MAX : item.duration;
    end else if (ctl.tick_step && !expire) begin
      rem_we = 1'b1;
    end
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = prev_ptr;
    link_wd = link_rd;
    if (ctl.do_start) begin
      link_we = list_nonempty;
      link_wa = tail;
      link_wd = free_idx;
    end else if (unlink) begin
      link_we = prev_valid;
    end
  end

  // Every store is read at the walk pointer; data is ready in the next cycle.
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_rd <= rem_mem[walk_ptr];
  end

  always_ff @(posedge clk) begin
    if (ctl.do_start) begin
      mbx_mem[free_idx] <= item.mailbox;
      val_mem[free_idx] <= item.ret_value;
    end
    mbx_rd <= mbx_mem[walk_ptr];
    val_rd <= val_mem[walk_ptr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[walk_ptr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      mask_q <= item.ready_mask;
      stop_idx <= req_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      head <= '0;
      tail <= '0;
      list_nonempty <= 1'b0;
      walk_ptr <= '0;
      prev_ptr <= '0;
      prev_valid <= 1'b0;
    end else begin
      if (ctl.do_start) begin
        active[free_idx] <= 1'b1;
        if (!list_nonempty) begin
          head <= free_idx;
        end
        tail <= free_idx;
        list_nonempty <= 1'b1;
      end
      if (ctl.walk_init) begin
        walk_ptr <= head;
        prev_valid <= 1'b0;
      end
      if (ctl.tick_step || ctl.stop_step) begin
        walk_ptr <= link_rd;
        if (unlink) begin
          active[walk_ptr] <= 1'b0;
          if (!prev_valid) begin
            head <= link_rd;
          end
          if (at_tail) begin
            if (prev_valid) begin
              tail <= prev_ptr;
            end else begin
              list_nonempty <= 1'b0;
            end
          end
        end else begin
          prev_ptr <= walk_ptr;
          prev_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.do_start || ctl.do_error || ctl.emit_done || unlink;
    end
  end

  always_comb begin
    result_next = '0;
    if (ctl.do_start) begin
      result_next.kind = KIND_STARTED;
      result_next.slot = 4'(free_idx);
      result_next.last = 1'b1;
    end else if (ctl.do_error) begin
      result_next.kind = KIND_ERROR;
      result_next.error_code = (item.command == CMD_START) ? ERR_NO_FREE : ERR_BAD_STOP;
      result_next.last = 1'b1;
    end else if (ctl.emit_done) begin
      result_next.kind = KIND_DONE;
      result_next.last = 1'b1;
    end else if (ctl.stop_step) begin
      result_next.kind = KIND_STOPPED;
      result_next.slot = 4'(stop_idx);
      result_next.last = 1'b1;
    end else if (ctl.tick_step) begin
      result_next.kind = KIND_EXPIRED;
      result_next.slot = 4'(walk_ptr);
      result_next.out_mailbox = mbx_rd;
      result_next.out_value = val_rd;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

[sv/mtq_checker.sv]
// Port-level checks for the timer queue unit, bound to the top level.
`include "multi_timer_queue_unit_assert.svh"

module mtq_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input mtq_pkg::mtq_in_t  item,
  input logic              result_valid,
  input mtq_pkg::mtq_out_t result
);
  import mtq_pkg::*;

  logic known_cmd;

  assign known_cmd = (item.command == CMD_TICK) || (item.command == CMD_START) ||
                     (item.command == CMD_STOP);

  // Reset leaves no result pending.
  `MTQ_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid)

  // A real command either keeps the unit busy or answers at once.
  `MTQ_ASSERT(a_cmd_answers, (start && !busy && known_cmd) |=> (busy || result_valid))

  // The unit goes idle only on the final result of a transaction.
  `MTQ_ASSERT(a_idle_on_last, (!$past(rst) && $fell(busy)) |-> (result_valid && result.last))

  `MTQ_ASSERT(a_done_last, (result_valid && result.kind == KIND_DONE) |-> result.last)

  `MTQ_ASSERT(a_error_code, (result_valid && result.kind == KIND_ERROR) |-> (result.error_code != ERR_NONE))

endmodule

bind multi_timer_queue_unit mtq_port_checks u_mtq_port_checks (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
